// File: src/oiq_pkg.sv
// Package for the ordered identifier queue: action and error codes, field widths,
// and the command and status structs that join the controller and the datapath.
// Depends on nothing.
`default_nettype none

package oiq_pkg;

   // Fixed widths of the channel fields.
   localparam int ACTION_W   = 3;
   localparam int IDENT_IO_W = 32;
   localparam int POS_W      = 4;
   localparam int COUNT_W    = 5;
   localparam int ERROR_W    = 2;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_PUSH     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP      = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ     = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd6;

   // Error codes returned with every response.
   localparam logic [ERROR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_EMPTY = 2'd2;
   localparam logic [ERROR_W-1:0] ERR_RANGE = 2'd3;

   // Memory read address selection.
   localparam logic [1:0] RD_FRONT = 2'd0;
   localparam logic [1:0] RD_NEXT  = 2'd1;
   localparam logic [1:0] RD_PREV  = 2'd2;
   localparam logic [1:0] RD_POS   = 2'd3;

   // Index counter operations.
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_ZERO = 3'd1;
   localparam logic [2:0] IDX_OCC  = 3'd2;
   localparam logic [2:0] IDX_INC  = 3'd3;
   localparam logic [2:0] IDX_DEC  = 3'd4;

   // Occupancy counter operations.
   localparam logic [1:0] OCC_HOLD = 2'd0;
   localparam logic [1:0] OCC_INC  = 2'd1;
   localparam logic [1:0] OCC_DEC  = 2'd2;
   localparam logic [1:0] OCC_CLR  = 2'd3;

   typedef struct packed {
      logic                load;
      logic                rd_en;
      logic [1:0]          rd_sel;
      logic                wr_en;
      logic                wr_at_occ;
      logic                wr_from_id;
      logic [2:0]          idx_op;
      logic [1:0]          occ_op;
      logic                set_found;
      logic                set_item;
      logic                set_err;
      logic [ERROR_W-1:0]  err_code;
      logic                rsp_load;
   } oiq_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                full;
      logic                empty;
      logic                ins_more;
      logic                shl_more;
      logic                idx_zero;
      logic                match;
      logic                read_oor;
   } oiq_status_type;

endpackage

`default_nettype wire

// File: src/oiq_req_if.sv
// Request and response channel interfaces of the ordered identifier queue.
// Depends on oiq_pkg for the field widths.
`default_nettype none

interface oiq_req_if;
   import oiq_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [IDENT_IO_W-1:0] ident;
   logic [POS_W-1:0]    position;

   modport source (output valid, action, ident, position, input ready);
   modport sink   (input valid, action, ident, position, output ready);
endinterface

interface oiq_rsp_if;
   import oiq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [IDENT_IO_W-1:0] item;
   logic                  found;
   logic [COUNT_W-1:0]    count;
   logic [ERROR_W-1:0]    error;

   modport source (output valid, item, found, count, error, input ready);
   modport sink   (input valid, item, found, count, error, output ready);
endinterface

`default_nettype wire

// File: src/oiq_datapath.sv
// Datapath of the ordered identifier queue: entry memory, occupancy and index
// counters, request capture and the response register. Depends on oiq_pkg.
`default_nettype none

module oiq_datapath #(
   parameter int DEPTH   = 16,
   parameter int IDENT_W = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire oiq_pkg::oiq_cmd_type            cmd,
   output      oiq_pkg::oiq_status_type         status,
   input  wire logic [oiq_pkg::ACTION_W-1:0]    req_action,
   input  wire logic [oiq_pkg::IDENT_IO_W-1:0]  req_ident,
   input  wire logic [oiq_pkg::POS_W-1:0]       req_position,
   output      logic [oiq_pkg::IDENT_IO_W-1:0]  rsp_item,
   output      logic                            rsp_found,
   output      logic [oiq_pkg::COUNT_W-1:0]     rsp_count,
   output      logic [oiq_pkg::ERROR_W-1:0]     rsp_error
);
   import oiq_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int WIDE_W = CNT_W + POS_W;

   logic [IDENT_W-1:0]    mem [DEPTH];

   logic [ACTION_W-1:0]   act_ff;
   logic [IDENT_W-1:0]    id_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [IDENT_W-1:0]    rd_data_ff;
   logic                  found_ff;
   logic [IDENT_W-1:0]    item_ff;
   logic [ERROR_W-1:0]    err_ff;

   logic [IDENT_IO_W-1:0] rsp_item_ff;
   logic                  rsp_found_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [ERROR_W-1:0]    rsp_error_ff;

   logic [IDENT_W+IDENT_IO_W-1:0] id_wide;
   logic [IDENT_W+IDENT_IO_W-1:0] item_wide;
   logic [CNT_W+COUNT_W-1:0]      occ_out_wide;
   logic [WIDE_W-1:0]     occ_wide, pos_wide, idx_wide, ins_at;
   logic [CNT_W-1:0]      idx_plus, idx_minus;
   logic [IDX_W-1:0]      rd_addr, wr_addr;
   logic [IDENT_W-1:0]    wr_data;

   // Identifier width adaption, both directions, by zero extension and truncation.
   assign id_wide      = {{IDENT_W{1'b0}}, req_ident};
   assign item_wide    = {{IDENT_IO_W{1'b0}}, item_ff};
   assign occ_out_wide = {{COUNT_W{1'b0}}, occ_ff};

   assign occ_wide  = {{POS_W{1'b0}}, occ_ff};
   assign idx_wide  = {{POS_W{1'b0}}, idx_ff};
   assign pos_wide  = {{CNT_W{1'b0}}, pos_ff};
   assign ins_at    = (pos_wide < occ_wide) ? pos_wide : occ_wide;
   assign idx_plus  = idx_ff + CNT_W'(1);
   assign idx_minus = idx_ff - CNT_W'(1);

   always_comb begin
      status.action   = act_ff;
      status.full     = (occ_ff == CNT_W'(DEPTH));
      status.empty    = (occ_ff == '0);
      status.ins_more = (idx_wide > ins_at);
      status.shl_more = (idx_plus < occ_ff);
      status.idx_zero = (idx_ff == '0);
      status.match    = (rd_data_ff == id_ff);
      status.read_oor = (pos_wide >= occ_wide);
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_NEXT: rd_addr = idx_plus[IDX_W-1:0];
         RD_PREV: rd_addr = idx_minus[IDX_W-1:0];
         RD_POS:  rd_addr = pos_wide[IDX_W-1:0];
         default: rd_addr = '0;
      endcase
   end

   assign wr_addr = cmd.wr_at_occ ? occ_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.wr_from_id ? id_ff : rd_data_ff;

   always_comb begin
      case (cmd.idx_op)
         IDX_ZERO: idx_in = '0;
         IDX_OCC:  idx_in = occ_ff;
         IDX_INC:  idx_in = idx_plus;
         IDX_DEC:  idx_in = idx_minus;
         default:  idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.occ_op)
         OCC_INC: occ_in = occ_ff + CNT_W'(1);
         OCC_DEC: occ_in = occ_ff - CNT_W'(1);
         OCC_CLR: occ_in = '0;
         default: occ_in = occ_ff;
      endcase
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         act_ff   <= req_action;
         id_ff    <= id_wide[IDENT_W-1:0];
         pos_ff   <= req_position;
         found_ff <= 1'b0;
         item_ff  <= '0;
         err_ff   <= ERR_OK;
      end else begin
         if (cmd.set_found) begin
            found_ff <= 1'b1;
         end
         if (cmd.set_item) begin
            item_ff <= rd_data_ff;
         end
         if (cmd.set_err) begin
            err_ff <= cmd.err_code;
         end
      end
      if (cmd.rsp_load) begin
         rsp_item_ff  <= item_wide[IDENT_IO_W-1:0];
         rsp_found_ff <= found_ff;
         rsp_count_ff <= occ_out_wide[COUNT_W-1:0];
         rsp_error_ff <= err_ff;
      end
   end

   assign rsp_item  = rsp_item_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_error = rsp_error_ff;

endmodule

`default_nettype wire

// File: src/oiq_controller.sv
// Controller state machine of the ordered identifier queue. It sequences
// memory reads, writes and shifts per action. Depends on oiq_pkg.
`default_nettype none

module oiq_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire oiq_pkg::oiq_status_type status,
   output      oiq_pkg::oiq_cmd_type    cmd
);
   import oiq_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_POP_CAP  = 4'd2;
   localparam logic [3:0] S_SHL_RD   = 4'd3;
   localparam logic [3:0] S_SHL_WR   = 4'd4;
   localparam logic [3:0] S_SHR_RD   = 4'd5;
   localparam logic [3:0] S_SHR_WR   = 4'd6;
   localparam logic [3:0] S_SCAN_RD  = 4'd7;
   localparam logic [3:0] S_SCAN_CMP = 4'd8;
   localparam logic [3:0] S_READ_CAP = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (status.action)
               ACT_PUSH: begin
                  if (status.full) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ERR_FULL;
                  end else begin
                     cmd.wr_en      = 1'b1;
                     cmd.wr_at_occ  = 1'b1;
                     cmd.wr_from_id = 1'b1;
                     cmd.occ_op     = OCC_INC;
                  end
               end
               ACT_POP: begin
                  if (status.empty) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ERR_EMPTY;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_FRONT;
                     cmd.idx_op = IDX_ZERO;
                     state_in   = S_POP_CAP;
                  end
               end
               ACT_INSERT: begin
                  if (status.full) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ERR_FULL;
                  end else begin
                     cmd.idx_op = IDX_OCC;
                     state_in   = S_SHR_RD;
                  end
               end
               ACT_REMOVE, ACT_CONTAINS: begin
                  cmd.idx_op = IDX_OCC;
                  state_in   = S_SCAN_RD;
               end
               ACT_READ: begin
                  if (status.read_oor) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ERR_RANGE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     state_in   = S_READ_CAP;
                  end
               end
               ACT_CLEAR: begin
                  cmd.occ_op = OCC_CLR;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_POP_CAP: begin
            cmd.set_item = 1'b1;
            state_in     = S_SHL_RD;
         end
         S_SHL_RD: begin
            if (status.shl_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = S_SHL_WR;
            end else begin
               cmd.occ_op = OCC_DEC;
               state_in   = S_DONE;
            end
         end
         S_SHL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = IDX_INC;
            state_in   = S_SHL_RD;
         end
         S_SHR_RD: begin
            if (status.ins_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
               state_in   = S_SHR_WR;
            end else begin
               cmd.wr_en      = 1'b1;
               cmd.wr_from_id = 1'b1;
               cmd.occ_op     = OCC_INC;
               state_in       = S_DONE;
            end
         end
         S_SHR_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = IDX_DEC;
            state_in   = S_SHR_RD;
         end
         S_SCAN_RD: begin
            if (status.idx_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
               cmd.idx_op = IDX_DEC;
               state_in   = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (status.match) begin
               cmd.set_found = 1'b1;
               state_in = (status.action == ACT_REMOVE) ? S_SHL_RD : S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_READ_CAP: begin
            cmd.set_item = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: src/ordered_id_queue_with_insert_remove.sv
// Top level of the ordered identifier queue: controller plus datapath.
// Depends on oiq_pkg, oiq_req_if, oiq_rsp_if, oiq_controller and oiq_datapath.
//
//   Channel  Direction  Handshake            Carries
//   req_if   in         valid/ready          action, ident, position
//   rsp_if   out        valid/ready          item, found, count, error
//
// A push, a clear or any request that ends in an error goes from decode to the
// response, and a read first captures the addressed entry. Pop and insert move
// the entries behind the affected position, one read and one write per entry.
// Remove and contains scan from the back, one entry per read, and remove then
// closes the gap the same way, so the worst case is a remove of the front entry
// of a full queue. The entry memory allows one write and one registered read
// a cycle. Reset empties the queue at once.
// The response sits in an output register; a request is taken while an older
// response still waits, and only the final response load stalls on rsp ready.
`default_nettype none

module ordered_id_queue_with_insert_remove #(
   parameter int DEPTH   = 16,
   parameter int IDENT_W = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   oiq_req_if.sink   req_if,
   oiq_rsp_if.source rsp_if
);
   import oiq_pkg::*;

   oiq_cmd_type    cmd;
   oiq_status_type status;

   // The controller owns all sequencing and both handshakes.
   oiq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the entries and drives the response payload.
   oiq_datapath #(
      .DEPTH   (DEPTH),
      .IDENT_W (IDENT_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_action   (req_if.action),
      .req_ident    (req_if.ident),
      .req_position (req_if.position),
      .rsp_item     (rsp_if.item),
      .rsp_found    (rsp_if.found),
      .rsp_count    (rsp_if.count),
      .rsp_error    (rsp_if.error)
   );

endmodule

`default_nettype wire

// File: src/oiq_checker.sv
// Port-level checks on the ordered identifier queue's response channel, and
// the bind that attaches them to the top level. Depends on oiq_pkg.
`default_nettype none

module oiq_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [oiq_pkg::IDENT_IO_W-1:0] rsp_item,
   input wire logic                           rsp_found,
   input wire logic [oiq_pkg::COUNT_W-1:0]    rsp_count,
   input wire logic [oiq_pkg::ERROR_W-1:0]    rsp_error
);
   import oiq_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   // A stalled response stays up.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_item) && $stable(rsp_found)
         && $stable(rsp_count) && $stable(rsp_error))
      else $error("response payload changed while stalled");

   // A dropped push or insert reports a full queue and nothing else.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == ERR_FULL |->
         rsp_count == FULL_COUNT && !rsp_found && rsp_item == '0)
      else $error("full error with a count other than the capacity");

   // A pop on an empty queue leaves it empty and returns nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == ERR_EMPTY |-> rsp_count == '0 && rsp_item == '0)
      else $error("empty error on a queue that holds entries");

   // Only a successful search sets found, and it returns no identifier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_error == ERR_OK && rsp_item == '0)
      else $error("found set together with an error or an identifier");

endmodule

bind ordered_id_queue_with_insert_remove oiq_checker #(
   .DEPTH (DEPTH)
) u_oiq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_item  (rsp_if.item),
   .rsp_found (rsp_if.found),
   .rsp_count (rsp_if.count),
   .rsp_error (rsp_if.error)
);

`default_nettype wire
